// File: rtl/rcam_pkg.sv
`timescale 1ns / 1ps

package rcam_pkg;

  localparam int COORD_BITS     = 12;
  localparam int COV_FRAC_BITS  = 8;
  localparam int CH_BITS        = 8;
  localparam int FRAME_BITS     = 13;
  localparam int RADIUS_BITS    = 8;
  localparam int COV_OUT_BITS   = 9;

  localparam int APB_ADDR_BITS  = 4;
  localparam int APB_DATA_BITS  = 32;

  localparam logic [1:0] REG_FRAME_WIDTH   = 2'd0;
  localparam logic [1:0] REG_FRAME_HEIGHT  = 2'd1;
  localparam logic [1:0] REG_CORNER_RADIUS = 2'd2;

  localparam logic [FRAME_BITS-1:0]  FRAME_WIDTH_RST   = FRAME_BITS'(760);
  localparam logic [FRAME_BITS-1:0]  FRAME_HEIGHT_RST  = FRAME_BITS'(520);
  localparam logic [RADIUS_BITS-1:0] CORNER_RADIUS_RST = RADIUS_BITS'(16);

  localparam int P2_BITS   = COORD_BITS + 1;
  localparam int E2_BITS   = FRAME_BITS + 1;
  localparam int R2_BITS   = RADIUS_BITS + 1;
  localparam int D_BITS    = ((P2_BITS > E2_BITS) ? P2_BITS : E2_BITS) + 2;
  localparam int MAG_BITS  = ((P2_BITS > R2_BITS) ? P2_BITS : R2_BITS) + 1;
  localparam int SQ_BITS   = 2 * MAG_BITS + 1;
  localparam int SQ_SHIFT  = 2 * COV_FRAC_BITS - 2;
  localparam int ROOT_BITS = (SQ_BITS + SQ_SHIFT + 1) / 2;
  localparam int VAL_BITS  = 2 * ROOT_BITS;
  localparam int REM_BITS  = ROOT_BITS + 2;
  localparam int COV_BITS  = COV_FRAC_BITS + 1;
  localparam int RQ_BITS   = RADIUS_BITS + COV_FRAC_BITS;
  localparam int CMP_BITS  = ((ROOT_BITS > RQ_BITS) ? ROOT_BITS : RQ_BITS) + 2;
  localparam int PROD_BITS = CH_BITS + COV_BITS + 1;

  localparam int ST_DIFF    = 0;
  localparam int ST_SQR     = 1;
  localparam int ST_SUM     = 2;
  localparam int ST_ROOT    = 3;
  localparam int ST_COV     = ST_ROOT + ROOT_BITS;
  localparam int ST_OUT     = ST_COV + 1;
  localparam int NUM_STAGES = ST_OUT + 1;

  typedef struct packed {
    logic [CH_BITS-1:0] blue;
    logic [CH_BITS-1:0] green;
    logic [CH_BITS-1:0] red;
    logic [CH_BITS-1:0] alpha;
    logic               in_rect;
  } side_t;

endpackage

// File: rtl/rcam_if.sv
`timescale 1ns / 1ps

interface rcam_pix_if;
  logic                                valid;
  logic                                ready;
  logic [rcam_pkg::COORD_BITS-1:0]     column;
  logic [rcam_pkg::COORD_BITS-1:0]     row;
  logic [rcam_pkg::CH_BITS-1:0]        in_blue;
  logic [rcam_pkg::CH_BITS-1:0]        in_green;
  logic [rcam_pkg::CH_BITS-1:0]        in_red;
  logic [rcam_pkg::CH_BITS-1:0]        in_alpha;

  modport source (output valid, column, row, in_blue, in_green, in_red, in_alpha,
                  input ready);
  modport sink (input valid, column, row, in_blue, in_green, in_red, in_alpha,
                output ready);
endinterface

interface rcam_res_if;
  logic                                valid;
  logic                                ready;
  logic [rcam_pkg::CH_BITS-1:0]        out_blue;
  logic [rcam_pkg::CH_BITS-1:0]        out_green;
  logic [rcam_pkg::CH_BITS-1:0]        out_red;
  logic [rcam_pkg::CH_BITS-1:0]        out_alpha;
  logic [rcam_pkg::COV_OUT_BITS-1:0]   coverage;

  modport source (output valid, out_blue, out_green, out_red, out_alpha, coverage,
                  input ready);
  modport sink (input valid, out_blue, out_green, out_red, out_alpha, coverage,
                output ready);
endinterface

// File: rtl/rounded_corner_alpha_mask_unit.sv
`timescale 1ns / 1ps

// Channel   Port     Role     Transfer
// pixel     pix_i    sink     valid & ready, column, row and four channel bytes
// result    res_o    source   valid & ready, four scaled bytes and coverage
// config    APB      slave    psel & penable & pwrite & pready, index paddr[3:2]
//
// One pixel per clock while res_o is ready; the pipeline depth at the default
// sizes is set by the square root, which resolves one bit per stage.
// Reset clears the valid bits and loads the register defaults.
// Each stage holds only while it is full and the stage after it is held, so
// empty stages keep filling while a result waits at the output.

module rounded_corner_alpha_mask_unit (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  rcam_pix_if.sink                             pix_i,
  rcam_res_if.source                           res_o,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [rcam_pkg::APB_ADDR_BITS-1:0]   paddr,
  input  logic [rcam_pkg::APB_DATA_BITS-1:0]   pwdata,
  output logic [rcam_pkg::APB_DATA_BITS-1:0]   prdata,
  output logic                                 pready
);

  localparam int NS = rcam_pkg::NUM_STAGES;
  localparam int RB = rcam_pkg::ROOT_BITS;

  logic [rcam_pkg::FRAME_BITS-1:0]  frame_width_q;
  logic [rcam_pkg::FRAME_BITS-1:0]  frame_height_q;
  logic [rcam_pkg::RADIUS_BITS-1:0] corner_radius_q;
  logic [1:0]                       reg_idx;
  logic                             reg_wr;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign reg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q   <= rcam_pkg::FRAME_WIDTH_RST;
      frame_height_q  <= rcam_pkg::FRAME_HEIGHT_RST;
      corner_radius_q <= rcam_pkg::CORNER_RADIUS_RST;
    end else if (reg_wr) begin
      unique case (reg_idx)
        rcam_pkg::REG_FRAME_WIDTH:   frame_width_q   <= pwdata[rcam_pkg::FRAME_BITS-1:0];
        rcam_pkg::REG_FRAME_HEIGHT:  frame_height_q  <= pwdata[rcam_pkg::FRAME_BITS-1:0];
        rcam_pkg::REG_CORNER_RADIUS: corner_radius_q <= pwdata[rcam_pkg::RADIUS_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      rcam_pkg::REG_FRAME_WIDTH:   prdata = rcam_pkg::APB_DATA_BITS'(frame_width_q);
      rcam_pkg::REG_FRAME_HEIGHT:  prdata = rcam_pkg::APB_DATA_BITS'(frame_height_q);
      rcam_pkg::REG_CORNER_RADIUS: prdata = rcam_pkg::APB_DATA_BITS'(corner_radius_q);
      default:                     prdata = '0;
    endcase
  end

  // Stage advance chain.
  logic [NS-1:0] vld_q;
  logic [NS:0]   adv;

  assign adv[NS]     = res_o.ready;
  assign pix_i.ready = adv[0];

  for (genvar k = 0; k < NS; k++) begin : g_adv
    assign adv[k] = !vld_q[k] || adv[k+1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      for (int k = 0; k < NS; k++) begin
        if (adv[k]) begin
          vld_q[k] <= (k == 0) ? pix_i.valid : vld_q[(k == 0) ? 0 : k - 1];
        end
      end
    end
  end

  // Clamp into the inner rectangle and take the offset magnitudes.
  logic signed [rcam_pkg::D_BITS-1:0] r2_s;
  logic signed [rcam_pkg::D_BITS-1:0] px2_s, py2_s;
  logic signed [rcam_pkg::D_BITS-1:0] hx_s, hy_s;
  logic                               x_lo, x_hi, y_lo, y_hi;
  logic signed [rcam_pkg::D_BITS-1:0] dx_s, dy_s;
  rcam_pkg::side_t                    side_d;

  always_comb begin
    r2_s  = rcam_pkg::D_BITS'({corner_radius_q, 1'b0});
    px2_s = rcam_pkg::D_BITS'({pix_i.column, 1'b1});
    py2_s = rcam_pkg::D_BITS'({pix_i.row, 1'b1});
    hx_s  = rcam_pkg::D_BITS'({frame_width_q, 1'b0}) - r2_s;
    hy_s  = rcam_pkg::D_BITS'({frame_height_q, 1'b0}) - r2_s;
    x_lo  = px2_s < r2_s;
    x_hi  = px2_s > hx_s;
    y_lo  = py2_s < r2_s;
    y_hi  = py2_s > hy_s;
    priority if (x_lo) dx_s = r2_s - px2_s;
    else if (x_hi)     dx_s = px2_s - hx_s;
    else               dx_s = '0;
    priority if (y_lo) dy_s = r2_s - py2_s;
    else if (y_hi)     dy_s = py2_s - hy_s;
    else               dy_s = '0;
    side_d.blue    = pix_i.in_blue;
    side_d.green   = pix_i.in_green;
    side_d.red     = pix_i.in_red;
    side_d.alpha   = pix_i.in_alpha;
    side_d.in_rect = !(x_lo || x_hi || y_lo || y_hi);
  end

  logic [rcam_pkg::MAG_BITS-1:0]   dx_q, dy_q;
  logic [2*rcam_pkg::MAG_BITS-1:0] sqx_q, sqy_q;
  logic [rcam_pkg::SQ_BITS-1:0]    sq_q;
  rcam_pkg::side_t                 side_diff_q, side_sqr_q, side_sum_q;

  always_ff @(posedge clk_i) begin
    if (adv[rcam_pkg::ST_DIFF]) begin
      dx_q        <= dx_s[rcam_pkg::MAG_BITS-1:0];
      dy_q        <= dy_s[rcam_pkg::MAG_BITS-1:0];
      side_diff_q <= side_d;
    end
    if (adv[rcam_pkg::ST_SQR]) begin
      sqx_q      <= dx_q * dx_q;
      sqy_q      <= dy_q * dy_q;
      side_sqr_q <= side_diff_q;
    end
    if (adv[rcam_pkg::ST_SUM]) begin
      sq_q       <= rcam_pkg::SQ_BITS'(sqx_q) + rcam_pkg::SQ_BITS'(sqy_q);
      side_sum_q <= side_sqr_q;
    end
  end

  // Restoring square root, one result bit per stage.
  logic [rcam_pkg::SQ_BITS-1:0]  rt_sq_q   [RB];
  logic [rcam_pkg::REM_BITS-1:0] rt_rem_q  [RB];
  logic [RB-1:0]                 rt_root_q [RB];
  rcam_pkg::side_t               rt_side_q [RB];

  for (genvar k = 0; k < RB; k++) begin : g_root
    logic [rcam_pkg::SQ_BITS-1:0]  sq_in;
    logic [rcam_pkg::REM_BITS-1:0] rem_in;
    logic [RB-1:0]                 root_in;
    rcam_pkg::side_t               side_in;
    logic [rcam_pkg::VAL_BITS-1:0] val;
    logic [rcam_pkg::REM_BITS-1:0] rem_cat, trial;
    logic                          take;

    if (k == 0) begin : g_first
      assign sq_in   = sq_q;
      assign rem_in  = '0;
      assign root_in = '0;
      assign side_in = side_sum_q;
    end else begin : g_next
      assign sq_in   = rt_sq_q[k-1];
      assign rem_in  = rt_rem_q[k-1];
      assign root_in = rt_root_q[k-1];
      assign side_in = rt_side_q[k-1];
    end

    assign val     = rcam_pkg::VAL_BITS'(sq_in) << rcam_pkg::SQ_SHIFT;
    assign rem_cat = {rem_in[rcam_pkg::REM_BITS-3:0],
                      val[rcam_pkg::VAL_BITS-1-2*k -: 2]};
    assign trial   = {root_in, 2'b01};
    assign take    = rem_cat >= trial;

    always_ff @(posedge clk_i) begin
      if (adv[rcam_pkg::ST_ROOT + k]) begin
        rt_sq_q[k]   <= sq_in;
        rt_rem_q[k]  <= take ? rem_cat - trial : rem_cat;
        rt_root_q[k] <= {root_in[RB-2:0], take};
        rt_side_q[k] <= side_in;
      end
    end
  end

  // Coverage from the distance.
  logic signed [rcam_pkg::CMP_BITS-1:0] dist_s, rq_s, lo_s, hi_s, rem_cov_s;
  logic [rcam_pkg::COV_BITS-1:0]        cov_d, cov_q;
  rcam_pkg::side_t                      side_cov_q;

  always_comb begin
    dist_s    = rcam_pkg::CMP_BITS'(rt_root_q[RB-1]);
    rq_s      = rcam_pkg::CMP_BITS'(corner_radius_q) <<< rcam_pkg::COV_FRAC_BITS;
    lo_s      = rq_s - rcam_pkg::CMP_BITS'(1 << (rcam_pkg::COV_FRAC_BITS - 1));
    hi_s      = rq_s + rcam_pkg::CMP_BITS'(1 << (rcam_pkg::COV_FRAC_BITS - 1));
    rem_cov_s = hi_s - dist_s;
    priority if (rt_side_q[RB-1].in_rect || dist_s <= lo_s) begin
      cov_d = rcam_pkg::COV_BITS'(1 << rcam_pkg::COV_FRAC_BITS);
    end else if (dist_s >= hi_s) begin
      cov_d = '0;
    end else begin
      cov_d = rem_cov_s[rcam_pkg::COV_BITS-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[rcam_pkg::ST_COV]) begin
      cov_q      <= cov_d;
      side_cov_q <= rt_side_q[RB-1];
    end
  end

  // Channel scaling with round half up.
  function automatic logic [rcam_pkg::CH_BITS-1:0] scale_ch(
    input logic [rcam_pkg::CH_BITS-1:0]  ch,
    input logic [rcam_pkg::COV_BITS-1:0] cov
  );
    logic [rcam_pkg::PROD_BITS-1:0] prod;
    prod = rcam_pkg::PROD_BITS'(ch) * rcam_pkg::PROD_BITS'(cov)
         + rcam_pkg::PROD_BITS'(1 << (rcam_pkg::COV_FRAC_BITS - 1));
    return prod[rcam_pkg::COV_FRAC_BITS +: rcam_pkg::CH_BITS];
  endfunction

  logic [rcam_pkg::CH_BITS-1:0]      blue_q, green_q, red_q, alpha_q;
  logic [rcam_pkg::COV_OUT_BITS-1:0] cov_out_q;

  always_ff @(posedge clk_i) begin
    if (adv[rcam_pkg::ST_OUT]) begin
      blue_q    <= scale_ch(side_cov_q.blue, cov_q);
      green_q   <= scale_ch(side_cov_q.green, cov_q);
      red_q     <= scale_ch(side_cov_q.red, cov_q);
      alpha_q   <= scale_ch(side_cov_q.alpha, cov_q);
      cov_out_q <= rcam_pkg::COV_OUT_BITS'(cov_q);
    end
  end

  assign res_o.valid     = vld_q[rcam_pkg::ST_OUT];
  assign res_o.out_blue  = blue_q;
  assign res_o.out_green = green_q;
  assign res_o.out_red   = red_q;
  assign res_o.out_alpha = alpha_q;
  assign res_o.coverage  = cov_out_q;

endmodule
